// ===== rtl/tht_pkg.sv =====
// Shared widths, operation kinds and status codes of the typed handle table.
`default_nettype none
package tht_pkg;

  localparam int unsigned IdxW       = 10;
  localparam int unsigned TypeW      = 7;
  localparam int unsigned WordW      = 64;
  localparam int unsigned SlotCount  = 1 << IdxW;
  localparam int unsigned CountW     = IdxW + 1;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned KindW      = 2;
  localparam int unsigned EntryW     = 1 + TypeW + WordW;
  localparam int unsigned InFieldsW  = IdxW + 2 * TypeW + WordW;
  localparam int unsigned InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = StatusW + IdxW + TypeW + WordW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [KindW-1:0] KIND_CREATE   = 2'd0;
  localparam logic [KindW-1:0] KIND_DELETE   = 2'd1;
  localparam logic [KindW-1:0] KIND_VALIDATE = 2'd2;
  localparam logic [KindW-1:0] KIND_GET      = 2'd3;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_INVALID  = 3'd1;
  localparam logic [StatusW-1:0] ST_DELETED  = 3'd2;
  localparam logic [StatusW-1:0] ST_MISMATCH = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd4;

endpackage
`default_nettype wire

// ===== rtl/tht_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module tht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/typed_handle_table_core.sv =====
// Typed handle table: slot allocation, handle checks and stored-word lookup.
//
// Requests arrive on the s_axis group; tuser carries the operation kind
// (create, delete, validate, get) and tdata the handle, the expected or new
// type and the word to store. Every request yields exactly one response on
// the m_axis group, with a status, the handle and, for a good get, the word.
// All slot state lives in one 72-bit wide, 1024-deep RAM with a registered
// read. A request is taken, its slot is read, and in the LOOK state the
// checks run and the slot is written back (new entry on create, cleared
// present bit on delete). No new request is taken until the current one
// leaves the LOOK state, as the slot RAM is read and then written back.
// The response sits in an output register, so one further request is taken
// while a response waits; that request then holds until the response leaves.
// Reset clears the allocation counter and the control state only; the RAM
// needs no clearing, since only slots below the counter are ever inspected.
`default_nettype none
module typed_handle_table_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata, from bit 0: handle_index, handle_type, expected_type, user_word
  input  wire logic [tht_pkg::InDataW-1:0]   s_axis_tdata_i,
  // tuser: kind
  input  wire logic [tht_pkg::KindW-1:0]     s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // tdata, from bit 0: status, result_index, result_type, word_out, zero pad
  output logic      [tht_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import tht_pkg::*;

  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_LOOK = 1'b1;

  logic state_q, state_d;
  logic [CountW-1:0] next_free_q, next_free_d;
  logic [KindW-1:0] kind_q;
  logic [IdxW-1:0] idx_q;
  logic [TypeW-1:0] typ_q, want_q;
  logic [WordW-1:0] word_q;
  logic out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic accept, finish;
  logic [EntryW-1:0] rd_entry, wr_entry;
  logic wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [StatusW-1:0] status;
  logic [IdxW-1:0] res_idx;
  logic [TypeW-1:0] res_type;
  logic [WordW-1:0] res_word;
  logic slot_present;
  logic [TypeW-1:0] slot_type;
  logic [WordW-1:0] slot_word;

  assign s_axis_tready_o = (state_q == STATE_IDLE);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign finish = (state_q == STATE_LOOK) && (!out_valid_q || m_axis_tready_i);

  assign slot_present = rd_entry[EntryW-1];
  assign slot_type    = rd_entry[WordW +: TypeW];
  assign slot_word    = rd_entry[WordW-1:0];

  tht_ram #(
    .WIDTH(EntryW),
    .DEPTH(SlotCount)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_entry),
    .re_i   (accept),
    .raddr_i(s_axis_tdata_i[IdxW-1:0]),
    .rdata_o(rd_entry)
  );

  always_comb begin
    status      = ST_OK;
    res_idx     = idx_q;
    res_type    = typ_q;
    res_word    = '0;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_entry    = {1'b0, slot_type, slot_word};
    next_free_d = next_free_q;
    if (kind_q == KIND_CREATE) begin
      res_idx  = '0;
      res_type = '0;
      wr_addr  = next_free_q[IdxW-1:0];
      wr_entry = {1'b1, want_q, word_q};
      if (want_q == '0) begin
        status = ST_INVALID;
      end else if (next_free_q == CountW'(SlotCount)) begin
        status = ST_FULL;
      end else begin
        res_idx     = next_free_q[IdxW-1:0];
        res_type    = want_q;
        wr_en       = finish;
        next_free_d = finish ? next_free_q + 1'b1 : next_free_q;
      end
    end else begin
      // Checks in priority order; the first failing one sets the status.
      if ((idx_q == '0) && (typ_q == '0)) begin
        status = ST_INVALID;
      end else if ({1'b0, idx_q} >= next_free_q) begin
        status = ST_INVALID;
      end else if (!slot_present) begin
        status = ST_DELETED;
      end else if (slot_type != typ_q) begin
        status = ST_MISMATCH;
      end else if ((kind_q == KIND_GET) && (want_q != '0) && (want_q != typ_q)) begin
        status = ST_MISMATCH;
      end else begin
        if (kind_q == KIND_DELETE) begin
          wr_en = finish;
        end
        if (kind_q == KIND_GET) begin
          res_word = slot_word;
        end
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      STATE_IDLE: begin
        if (accept) begin
          state_d = STATE_LOOK;
        end
      end
      STATE_LOOK: begin
        if (finish) begin
          state_d     = STATE_IDLE;
          out_valid_d = 1'b1;
          out_data_d  = OutDataW'({res_word, res_type, res_idx, status});
        end
      end
      default: state_d = STATE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_IDLE;
      next_free_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (accept) begin
      kind_q <= s_axis_tuser_i;
      idx_q  <= s_axis_tdata_i[IdxW-1:0];
      typ_q  <= s_axis_tdata_i[IdxW +: TypeW];
      want_q <= s_axis_tdata_i[IdxW+TypeW +: TypeW];
      word_q <= s_axis_tdata_i[IdxW+2*TypeW +: WordW];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
`default_nettype wire

// ===== rtl/tht_checker.sv =====
// Port-level checks of the typed handle table, bound to the top level.
`default_nettype none
module tht_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [tht_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import tht_pkg::*;

  logic [StatusW-1:0] st;
  logic [WordW-1:0] wd;

  assign st = m_axis_tdata_o[StatusW-1:0];
  assign wd = m_axis_tdata_o[StatusW+IdxW+TypeW +: WordW];

  // A response held back by the receiver stays posted.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("response dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("response changed while stalled");

  // Each request needs a slot read before the next one can be taken.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken during slot lookup");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (st == ST_OK || st == ST_INVALID || st == ST_DELETED ||
                         st == ST_MISMATCH || st == ST_FULL))
    else $error("unknown status code");

  // Only a successful request may carry a stored word.
  a_word_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (st != ST_OK) |-> (wd == '0))
    else $error("word returned with failing status");

endmodule

bind typed_handle_table_core tht_checker u_tht_checker (.*);
`default_nettype wire

// ===== tb/typed_handle_table_core_test.sv =====
// Self-checking testbench for the typed handle table core with a class-based scoreboard.
module typed_handle_table_core_test;
  import tht_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdxW-1:0]  index;
    logic [TypeW-1:0] htype;
    logic [TypeW-1:0] want_type;
    logic [WordW-1:0] word;
  } handle_request_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdxW-1:0]    index;
    logic [TypeW-1:0]   rtype;
    logic [WordW-1:0]   word;
  } handle_response_t;

  // Tracks the slot table as the block should see it and queues the responses it owes.
  class handle_table_scoreboard;
    bit                 slot_live [SlotCount];
    logic [TypeW-1:0]   slot_type [SlotCount];
    logic [WordW-1:0]   slot_word [SlotCount];
    int unsigned        issued;
    handle_response_t   pending [$];
    int unsigned        errors;

    function logic [StatusW-1:0] lookup_status(logic [IdxW-1:0] idx, logic [TypeW-1:0] typ,
                                               logic [TypeW-1:0] want);
      if (idx == 0 && typ == 0) return ST_INVALID;
      if (idx >= issued) return ST_INVALID;
      if (!slot_live[idx]) return ST_DELETED;
      if (slot_type[idx] != typ) return ST_MISMATCH;
      if (want != 0 && want != typ) return ST_MISMATCH;
      return ST_OK;
    endfunction

    function void note_request(handle_request_t r);
      handle_response_t e;
      e = '0;
      if (r.kind == KIND_CREATE) begin
        if (r.want_type == 0) begin
          e.status = ST_INVALID;
        end else if (issued >= SlotCount) begin
          e.status = ST_FULL;
        end else begin
          slot_live[issued] = 1'b1;
          slot_type[issued] = r.want_type;
          slot_word[issued] = r.word;
          e.status = ST_OK;
          e.index = IdxW'(issued);
          e.rtype = r.want_type;
          issued++;
        end
      end else begin
        e.index = r.index;
        e.rtype = r.htype;
        // Only a get looks at the expected type.
        e.status = lookup_status(r.index, r.htype,
                                 (r.kind == KIND_GET) ? r.want_type : TypeW'(0));
        if (e.status == ST_OK) begin
          if (r.kind == KIND_DELETE) slot_live[r.index] = 1'b0;
          else if (r.kind == KIND_GET) e.word = slot_word[r.index];
        end
      end
      pending.push_back(e);
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_response(logic [OutDataW-1:0] d);
      handle_response_t e;
      if (pending.size() == 0) begin
        $error("response: expected none, got %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare_field("status", 64'(e.status), 64'(d[StatusW-1:0]));
      compare_field("result_index", 64'(e.index), 64'(d[StatusW +: IdxW]));
      compare_field("result_type", 64'(e.rtype), 64'(d[StatusW+IdxW +: TypeW]));
      compare_field("word_out", e.word, d[StatusW+IdxW+TypeW +: WordW]);
      compare_field("pad", 64'(0), 64'(d[OutDataW-1:OutFieldsW]));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [InDataW-1:0]    s_axis_tdata_i = '0;
  logic [KindW-1:0]      s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata_o;

  handle_table_scoreboard table_sb = new();

  int unsigned sent_count = 0;
  int unsigned send_idle_pct = 20;
  int unsigned rcv_pct = 0;
  int unsigned rcv_cycle = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  logic        hold_off = 1'b0;
  logic        quiet_tail = 1'b0;

  typed_handle_table_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_request(input handle_request_t r);
    if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= InDataW'({$urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {r.word, r.want_type, r.htype, r.index};
    s_axis_tuser_i <= r.kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    table_sb.note_request(r);
    sent_count++;
  endtask

  task automatic send_op(input logic [KindW-1:0] kind, input logic [IdxW-1:0] idx,
                         input logic [TypeW-1:0] htype, input logic [TypeW-1:0] want,
                         input logic [WordW-1:0] word);
    handle_request_t r;
    r.kind = kind;
    r.index = idx;
    r.htype = htype;
    r.want_type = want;
    r.word = word;
    send_request(r);
  endtask

  // Mostly handles that were issued, with the right type most of the time.
  function automatic handle_request_t random_request();
    handle_request_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.index = IdxW'($urandom);
    r.htype = TypeW'($urandom);
    r.want_type = TypeW'($urandom);
    r.word = {$urandom, $urandom};
    if (pick < 50) begin
      r.kind = KIND_CREATE;
      r.want_type = ($urandom_range(0, 19) == 0) ? TypeW'(0) : TypeW'($urandom_range(1, 127));
      return r;
    end
    r.kind = (pick < 62) ? KIND_DELETE : (pick < 81) ? KIND_VALIDATE : KIND_GET;
    if (table_sb.issued != 0 && $urandom_range(0, 99) < 80) begin
      r.index = IdxW'($urandom_range(0, table_sb.issued - 1));
      if ($urandom_range(0, 99) < 85) r.htype = table_sb.slot_type[r.index];
      case ($urandom_range(0, 2))
        0: r.want_type = '0;
        1: r.want_type = r.htype;
        default: ;
      endcase
    end else if ($urandom_range(0, 9) == 0) begin
      r.index = '0;
      r.htype = '0;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) table_sb.check_response(m_axis_tdata_o);
      if (rcv_cycle % 256 == 0) begin
        case ($urandom_range(0, 2))
          0: rcv_pct = 0;
          1: rcv_pct = 15;
          default: rcv_pct = 40;
        endcase
      end
      rcv_cycle++;
      if (stall_left != 0) stall_left--;
      else if (!quiet_tail && $urandom_range(0, 99) < rcv_pct) stall_left = $urandom_range(1, 5);
      m_axis_tready_i <= !hold_off && stall_left == 0;
    end
  end

  // One long stall on the response side so the block backs up into its input.
  initial begin
    @(posedge clk_i);
    while (sent_count < 60) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lookups on an empty table, then a few creates and every lookup outcome.
    send_op(KIND_GET, '0, '0, '0, '0);
    send_op(KIND_VALIDATE, '0, 7'd5, '0, '0);
    send_op(KIND_CREATE, '0, '0, '0, {WordW{1'b1}});
    send_op(KIND_CREATE, '0, '0, 7'd127, {WordW{1'b1}});
    send_op(KIND_CREATE, '1, '1, 7'd1, '0);
    send_op(KIND_CREATE, '0, '0, 7'h55, 64'hA5A5_A5A5_5A5A_5A5A);
    send_op(KIND_VALIDATE, 10'd0, 7'd127, '0, '0);
    send_op(KIND_GET, 10'd0, 7'd127, '0, '0);
    send_op(KIND_GET, 10'd0, 7'd127, 7'd127, '0);
    send_op(KIND_GET, 10'd0, 7'd127, 7'd1, '0);
    send_op(KIND_VALIDATE, 10'd1, 7'd2, '0, '0);
    send_op(KIND_GET, 10'd1, 7'd1, '0, '1);
    send_op(KIND_DELETE, 10'd1, 7'd1, '0, '0);
    send_op(KIND_DELETE, 10'd1, 7'd1, '0, '0);
    send_op(KIND_GET, 10'd1, 7'd1, 7'd1, '0);
    send_op(KIND_VALIDATE, 10'd3, 7'h55, '0, '0);
    send_op(KIND_VALIDATE, 10'd1023, 7'd127, '0, '0);
    send_op(KIND_VALIDATE, 10'd0, 7'd127, 7'd3, '0);
    send_op(KIND_DELETE, 10'd2, 7'h55, 7'd7, '0);
    send_op(KIND_GET, 10'd2, 7'h55, '0, '0);
    send_op(KIND_CREATE, '1, '1, 7'd42, 64'h0123_4567_89AB_CDEF);
    send_op(KIND_GET, 10'd3, 7'd42, 7'd42, '0);

    for (int n = 0; n < 780; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: send_idle_pct = 0;
          1: send_idle_pct = 10;
          default: send_idle_pct = 35;
        endcase
      end
      send_request(random_request());
    end

    // Back to back to the end: a few creates and lookups of the newest slot.
    quiet_tail <= 1'b1;
    send_op(KIND_CREATE, '0, '0, 7'd9, '1);
    send_op(KIND_CREATE, '0, '0, '0, '1);
    send_op(KIND_GET, IdxW'(table_sb.issued - 1), table_sb.slot_type[table_sb.issued - 1],
            '0, '0);
    send_op(KIND_VALIDATE, IdxW'(table_sb.issued - 1), ~table_sb.slot_type[table_sb.issued - 1],
            '0, '0);
    repeat (40) send_request(random_request());

    s_axis_tvalid_i <= 1'b0;
    while (table_sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (table_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tht_pkg.sv
rtl/tht_ram.sv
rtl/typed_handle_table_core.sv
rtl/tht_checker.sv
tb/typed_handle_table_core_test.sv
